// ===== rtl/gfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, constants and helper functions of the GNSS frame demux.
// ----------------------------------------------------------------------------
package gfd_pkg;

  // Line buffer geometry
  localparam int unsigned BufDepth = 2048;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned FillW    = AddrW + 1;
  localparam int unsigned MaxHits  = 8;
  localparam int unsigned HitW     = $clog2(MaxHits + 1);

  // Frame markers
  localparam logic [7:0]  ChDollar   = 8'h24;
  localparam logic [7:0]  ChStar     = 8'h2A;
  localparam logic [7:0]  UbxSync1   = 8'hB5;
  localparam logic [7:0]  UbxSync2   = 8'h62;
  localparam logic [7:0]  RtcmPre    = 8'hD3;
  localparam logic [15:0] RtcmLenLim = 16'd1023;
  localparam logic [23:0] Crc24Mask  = 24'hFFFFFF;
  localparam logic [24:0] Crc24Poly  = 25'h1864CFB;

  // Frame kind codes
  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindNmea = 2'd1,
    KindUbx  = 2'd2,
    KindRtcm = 2'd3
  } frame_kind_e;

  // One result word
  typedef struct packed {
    frame_kind_e      kind;
    logic [10:0]      start;
    logic [11:0]      frame_len;
    logic [11:0]      pay_len;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [11:0]      fill;
    logic [11:0]      peak;
    logic             ovf;
    logic             last;
  } res_t;

  // Line buffer RAM access
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // ASCII hex digit value, non-digits count as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    return v;
  endfunction

  // CRC-24Q update by one byte, MSB first
  function automatic logic [23:0] crc24_step(input logic [23:0] crc, input logic [7:0] d);
    logic [24:0] c;
    c = {1'b0, crc ^ {d, 16'h0000}};
    for (int b = 0; b < 8; b++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) c = c ^ Crc24Poly;
    end
    return c[23:0] & Crc24Mask;
  endfunction

endpackage

// ===== rtl/gfd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gfd_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfd_scan
// Buffer sequencer: appends bytes to the circular line buffer and searches
// it for NMEA, UBX and RTCM3 frames, each buffer byte read as an address then a data phase.
// ----------------------------------------------------------------------------
module gfd_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        byte_i,
  output logic              idle_o,
  output gfd_pkg::ram_req_t ram_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output gfd_pkg::res_t     res_o
);
  import gfd_pkg::*;

  typedef enum logic [19:0] {
    StIdle  = 20'h00001,
    StLoop  = 20'h00002,
    StNDol  = 20'h00004,
    StNStar = 20'h00008,
    StNHi   = 20'h00010,
    StNLo   = 20'h00020,
    StUHdr  = 20'h00040,
    StUSyn  = 20'h00080,
    StUL0   = 20'h00100,
    StUL1   = 20'h00200,
    StUSum  = 20'h00400,
    StUCk   = 20'h00800,
    StRHdr  = 20'h01000,
    StRL0   = 20'h02000,
    StRL1   = 20'h04000,
    StRCrc  = 20'h08000,
    StRCk   = 20'h10000,
    StHit   = 20'h20000,
    StFin   = 20'h40000,
    StPush  = 20'h80000
  } state_e;

  state_e           state_q, state_d, nxt_q, nxt_d;
  logic             ph_q, ph_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d, peak_q, peak_d;
  logic             ovf_q, ovf_d;
  logic [HitW-1:0]  hits_q, hits_d;
  logic [FillW-1:0] ptr_q, ptr_d, ix_q, ix_d;
  logic [7:0]       acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [23:0]      crc_q, crc_d, tmp_q, tmp_d;
  logic [15:0]      pl_q, pl_d;
  logic [7:0]       cls_q, cls_d, id_q, id_d;
  logic             ok_q, ok_d;
  logic [1:0]       cnt_q, cnt_d;
  frame_kind_e      hkind_q, hkind_d;
  logic [FillW-1:0] hlen_q, hlen_d, hpay_q, hpay_d;
  res_t             pend_q, pend_d, out_q, out_d;
  logic             pend_v_q, pend_v_d;

  logic [FillW-1:0] rd_off, avail, fill_inc, ubx_end, rtcm_end, frame_end;
  logic [15:0]      pl_new;
  logic [7:0]       d, sum_a;
  res_t             hit_res;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      nxt_q    <= StIdle;
      ph_q     <= 1'b0;
      head_q   <= '0;
      fill_q   <= '0;
      peak_q   <= '0;
      ovf_q    <= 1'b0;
      hits_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nxt_q    <= nxt_d;
      ph_q     <= ph_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      peak_q   <= peak_d;
      ovf_q    <= ovf_d;
      hits_q   <= hits_d;
      pend_v_q <= pend_v_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    ix_q    <= ix_d;
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
    crc_q   <= crc_d;
    tmp_q   <= tmp_d;
    pl_q    <= pl_d;
    cls_q   <= cls_d;
    id_q    <= id_d;
    ok_q    <= ok_d;
    cnt_q   <= cnt_d;
    hkind_q <= hkind_d;
    hlen_q  <= hlen_d;
    hpay_q  <= hpay_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign d         = ram_rdata_i;
  assign avail     = fill_q - ix_q;
  assign fill_inc  = fill_q + FillW'(1);
  assign ubx_end   = ix_q + FillW'(6) + pl_q[FillW-1:0];
  assign rtcm_end  = ix_q + FillW'(3) + pl_q[FillW-1:0];
  assign frame_end = ix_q + hlen_q;
  assign sum_a     = acc_a_q + d;

  // read offset per state
  always_comb begin
    case (state_q)
      StNHi:          rd_off = ptr_q + FillW'(1);
      StNLo:          rd_off = ptr_q + FillW'(2);
      StUHdr, StRHdr: rd_off = ix_q;
      StUSyn, StRL0:  rd_off = ix_q + FillW'(1);
      StRL1:          rd_off = ix_q + FillW'(2);
      StUL0:          rd_off = ix_q + FillW'(4);
      StUL1:          rd_off = ix_q + FillW'(5);
      StUCk, StRCk:   rd_off = ptr_q + FillW'(cnt_q);
      default:        rd_off = ptr_q;
    endcase
  end

  // descriptor of the frame just found
  always_comb begin
    hit_res           = '0;
    hit_res.kind      = hkind_q;
    hit_res.start     = ix_q[AddrW-1:0];
    hit_res.frame_len = hlen_q;
    hit_res.pay_len   = hpay_q;
    hit_res.msg_class = (hkind_q == KindUbx) ? cls_q : 8'h00;
    hit_res.msg_id    = (hkind_q == KindUbx) ? id_q : 8'h00;
    hit_res.fill      = fill_q - frame_end;
    hit_res.peak      = peak_q;
    hit_res.ovf       = ovf_q;
    hit_res.last      = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    nxt_d    = nxt_q;
    ph_d     = ph_q;
    head_d   = head_q;
    fill_d   = fill_q;
    peak_d   = peak_q;
    ovf_d    = ovf_q;
    hits_d   = hits_q;
    ptr_d    = ptr_q;
    ix_d     = ix_q;
    acc_a_d  = acc_a_q;
    acc_b_d  = acc_b_q;
    crc_d    = crc_q;
    tmp_d    = tmp_q;
    pl_d     = pl_q;
    cls_d    = cls_q;
    id_d     = id_q;
    ok_d     = ok_q;
    cnt_d    = cnt_q;
    hkind_d  = hkind_q;
    hlen_d   = hlen_q;
    hpay_d   = hpay_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    pl_new   = 16'h0000;
    ram_o       = '0;
    ram_o.raddr = head_q + rd_off[AddrW-1:0];
    ram_o.waddr = head_q + fill_q[AddrW-1:0];
    ram_o.wdata = byte_i;
    res_valid_o = 1'b0;

    unique case (state_q)
      // append the byte, clear a full buffer
      StIdle: begin
        if (start_i) begin
          ram_o.we = 1'b1;
          hits_d   = '0;
          pend_v_d = 1'b0;
          ph_d     = 1'b0;
          state_d  = StLoop;
          if (fill_inc == FillW'(BufDepth)) begin
            fill_d = '0;
            ovf_d  = 1'b1;
          end else begin
            fill_d = fill_inc;
            ovf_d  = 1'b0;
            if (fill_inc > peak_q) peak_d = fill_inc;
          end
        end
      end

      // top of one search round
      StLoop: begin
        if (fill_q == '0 || hits_q == HitW'(MaxHits)) begin
          state_d = StFin;
        end else begin
          ptr_d   = '0;
          state_d = StNDol;
        end
      end

      // NMEA: find '$'
      StNDol: begin
        if (!ph_q) begin
          if (ptr_q >= fill_q) begin
            ix_d    = '0;
            state_d = StUHdr;
          end else ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (d == 8'h00) begin
            ix_d    = '0;
            state_d = StUHdr;
          end else if (d == ChDollar) begin
            ix_d    = ptr_q;
            acc_a_d = 8'h00;
            ptr_d   = ptr_q + FillW'(1);
            state_d = StNStar;
          end else ptr_d = ptr_q + FillW'(1);
        end
      end

      // NMEA: find '*', xor the text
      StNStar: begin
        if (!ph_q) begin
          if (ptr_q >= fill_q) begin
            ix_d    = '0;
            state_d = StUHdr;
          end else ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (d == 8'h00) begin
            ix_d    = '0;
            state_d = StUHdr;
          end else if (d == ChStar) begin
            if (ptr_q + FillW'(3) > fill_q) begin
              ix_d    = '0;
              state_d = StUHdr;
            end else state_d = StNHi;
          end else begin
            acc_a_d = acc_a_q ^ d;
            ptr_d   = ptr_q + FillW'(1);
          end
        end
      end

      // NMEA: checksum digits
      StNHi: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          tmp_d[3:0] = hex_val(d);
          state_d    = StNLo;
        end
      end

      StNLo: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if ({tmp_q[3:0], hex_val(d)} == acc_a_q) begin
            hkind_d = KindNmea;
            hlen_d  = ptr_q - ix_q + FillW'(3);
            hpay_d  = ptr_q - ix_q - FillW'(1);
            state_d = StHit;
          end else begin
            ix_d    = '0;
            state_d = StUHdr;
          end
        end
      end

      // UBX: sync bytes
      StUHdr: begin
        if (!ph_q) begin
          if (avail <= FillW'(8)) begin
            ix_d    = '0;
            state_d = StRHdr;
          end else ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (d == UbxSync1) state_d = StUSyn;
          else ix_d = ix_q + FillW'(1);
        end
      end

      StUSyn: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (d == UbxSync2) state_d = StUL0;
          else begin
            ix_d    = ix_q + FillW'(1);
            state_d = StUHdr;
          end
        end
      end

      // UBX: length field
      StUL0: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          pl_d[7:0] = d;
          state_d   = StUL1;
        end
      end

      StUL1: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          pl_new = {d, pl_q[7:0]};
          pl_d   = pl_new;
          if ({5'b0, avail} < {1'b0, pl_new} + 17'd8) begin
            ix_d    = '0;
            state_d = StRHdr;
          end else begin
            ptr_d   = ix_q + FillW'(2);
            acc_a_d = 8'h00;
            acc_b_d = 8'h00;
            state_d = StUSum;
          end
        end
      end

      // UBX: Fletcher sum over class..payload
      StUSum: begin
        if (!ph_q) begin
          if (ptr_q == ubx_end) begin
            cnt_d   = 2'd0;
            state_d = StUCk;
          end else ph_d = 1'b1;
        end else begin
          ph_d    = 1'b0;
          acc_a_d = sum_a;
          acc_b_d = acc_b_q + sum_a;
          if (ptr_q == ix_q + FillW'(2)) cls_d = d;
          if (ptr_q == ix_q + FillW'(3)) id_d = d;
          ptr_d = ptr_q + FillW'(1);
        end
      end

      StUCk: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (cnt_q == 2'd0) begin
            ok_d  = (d == acc_a_q);
            cnt_d = 2'd1;
          end else if (ok_q && d == acc_b_q) begin
            hkind_d = KindUbx;
            hlen_d  = pl_q[FillW-1:0] + FillW'(8);
            hpay_d  = pl_q[FillW-1:0];
            state_d = StHit;
          end else begin
            ix_d    = ix_q + FillW'(1);
            state_d = StUHdr;
          end
        end
      end

      // RTCM3: preamble
      StRHdr: begin
        if (!ph_q) begin
          if (avail <= FillW'(6)) state_d = StFin;
          else ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (d == RtcmPre) state_d = StRL0;
          else ix_d = ix_q + FillW'(1);
        end
      end

      StRL0: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          pl_d[15:8] = d;
          state_d    = StRL1;
        end
      end

      StRL1: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          pl_new = {pl_q[15:8], d};
          pl_d   = pl_new;
          if (pl_new == 16'h0000 || pl_new >= RtcmLenLim) begin
            ix_d    = ix_q + FillW'(1);
            state_d = StRHdr;
          end else if ({4'b0, avail} < pl_new + 16'd6) begin
            state_d = StFin;
          end else begin
            ptr_d   = ix_q;
            crc_d   = 24'h000000;
            state_d = StRCrc;
          end
        end
      end

      // RTCM3: CRC-24Q over header and payload
      StRCrc: begin
        if (!ph_q) begin
          if (ptr_q == rtcm_end) begin
            cnt_d   = 2'd0;
            tmp_d   = 24'h000000;
            state_d = StRCk;
          end else ph_d = 1'b1;
        end else begin
          ph_d  = 1'b0;
          crc_d = crc24_step(crc_q, d);
          ptr_d = ptr_q + FillW'(1);
        end
      end

      StRCk: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          tmp_d = {tmp_q[15:0], d};
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            if ({tmp_q[15:0], d} == crc_q) begin
              hkind_d = KindRtcm;
              hlen_d  = pl_q[FillW-1:0] + FillW'(6);
              hpay_d  = pl_q[FillW-1:0];
              state_d = StHit;
            end else begin
              ix_d    = ix_q + FillW'(1);
              state_d = StRHdr;
            end
          end
        end
      end

      // drop the frame, hold its descriptor until the next one is known
      StHit: begin
        head_d   = head_q + frame_end[AddrW-1:0];
        fill_d   = fill_q - frame_end;
        hits_d   = hits_q + HitW'(1);
        pend_d   = hit_res;
        pend_v_d = 1'b1;
        if (pend_v_q) begin
          out_d   = pend_q;
          nxt_d   = StLoop;
          state_d = StPush;
        end else state_d = StLoop;
      end

      // final word of this byte
      StFin: begin
        if (pend_v_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
        end else begin
          out_d      = '0;
          out_d.kind = KindNone;
          out_d.fill = fill_q;
          out_d.peak = peak_q;
          out_d.ovf  = ovf_q;
          out_d.last = 1'b1;
        end
        pend_v_d = 1'b0;
        nxt_d    = StIdle;
        state_d  = StPush;
      end

      // hand a word to the output register
      StPush: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = nxt_q;
      end

      default: state_d = StIdle;
    endcase
  end

  assign idle_o = (state_q == StIdle);
  assign res_o  = out_q;

endmodule

// ===== rtl/gnss_frame_demux_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_frame_demux_unit
// Byte stream in, frame descriptors out: NMEA, UBX and RTCM3 detection.
// ----------------------------------------------------------------------------
// Each received byte goes into a 2048-byte circular line buffer held in one
// RAM with a registered read port. The buffer is then searched for NMEA, UBX
// and RTCM3 frames in that order, up to eight hits per byte, and each hit
// gives one descriptor word (tlast on the final word of the byte). The RAM
// read port sets the pace: every buffer byte visited is read as an address
// phase, then a registered data phase. A search round visits each byte looked
// at by the NMEA pass, the UBX header pass and the RTCM3 header pass, and each
// byte summed for every UBX or RTCM3 header that passes its length check; a
// hit adds a drop state and the hand-off of a word. Search time grows with the
// fill level, and far more when many headers each span most of the buffer.
// A new byte is taken once the previous byte's last word sits in the output
// register; no clearing pass is needed after reset.
module gnss_frame_demux_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [10:0] frame_start, [22:11] frame_length,
                                      // [34:23] payload_length, [42:35] msg_class,
                                      // [50:43] msg_id, [62:51] fill_level,
                                      // [74:63] peak_fill, [75] overflowed, rest 0
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_kind
  output logic        m_axis_tlast    // last
);
  import gfd_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       scan_idle, res_valid, res_ready, in_acc;
  res_t       res, res_q;
  logic       m_valid_q;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = scan_idle;

  // line buffer
  gfd_ram #(
    .Width(8),
    .Depth(BufDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  // search sequencer
  gfd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .byte_i     (s_axis_tdata),
    .idle_o     (scan_idle),
    .ram_o      (ram_req),
    .ram_rdata_i(ram_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register
  assign res_ready = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (res_ready) m_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {4'h0, res_q.ovf, res_q.peak, res_q.fill, res_q.msg_id,
                          res_q.msg_class, res_q.pay_len, res_q.frame_len, res_q.start};

  // an overflow word never carries a frame
  a_ovf_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[75] |-> m_axis_tuser == KindNone)
    else $error("overflow word reports a frame");

  // a reported frame lies inside the buffer
  a_frame_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KindNone |->
      {1'b0, m_axis_tdata[10:0]} + m_axis_tdata[22:11] <= 12'(BufDepth - 1))
    else $error("frame runs past the buffer");

  // the sequencer is busy right after taking a byte
  a_busy_after_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("byte taken while search pending");

endmodule

// ===== bench/gnss_frame_demux_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_frame_demux_unit_tb
// Self-checking bench for the GNSS frame demux.
// ----------------------------------------------------------------------------
// Bytes are streamed in: valid NMEA, UBX and RTCM3 frames with random
// content, corrupted frames, noise, and a broken UBX frame wrapping two good
// ones so that one byte releases several frames. A behavioral model of the
// buffer search predicts every descriptor word, and a scoreboard compares
// each output word in order.
// ----------------------------------------------------------------------------
module gnss_frame_demux_unit_tb;
  import gfd_pkg::*;

  // Expected descriptor for one output word
  typedef struct {
    logic [1:0]  kind;
    logic [10:0] start;
    logic [11:0] flen;
    logic [11:0] plen;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [11:0] fill;
    logic [11:0] peak;
    logic        ovf;
    logic        last;
  } desc_t;

  // Scoreboard: frame predictor plus queue of pending descriptors
  class frame_scoreboard;
    byte unsigned lbuf[BufDepth];
    int unsigned  fill_cnt;
    int unsigned  peak_cnt;
    desc_t        pending[$];
    int           n_err;
    int           n_words;

    function int unsigned hexv(byte unsigned c);
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "0" && c <= "9") return c - "0";
      return 0;
    endfunction

    // CRC-24Q over a span of the model buffer
    function logic [23:0] crc24_of(int unsigned from, int unsigned n);
      logic [24:0] c;
      c = '0;
      for (int unsigned k = 0; k < n; k++) begin
        c[23:16] ^= lbuf[from+k];
        for (int j = 0; j < 8; j++) begin
          c = {c[23:0], 1'b0};
          if (c[24]) c ^= Crc24Poly;
        end
      end
      return c[23:0];
    endfunction

    function bit seek_nmea(output int unsigned st, output int unsigned ln,
                           output int unsigned pl);
      int unsigned s, e, x;
      bit got;
      s = 0; e = 0; x = 0; got = 0; st = 0; ln = 0; pl = 0;
      for (int unsigned i = 0; i < fill_cnt; i++) begin
        if (lbuf[i] == 0) break;
        if (lbuf[i] == ChDollar) begin s = i; got = 1; break; end
      end
      if (!got) return 0;
      got = 0;
      for (int unsigned i = s; i < fill_cnt; i++) begin
        if (lbuf[i] == 0) break;
        if (lbuf[i] == ChStar) begin e = i; got = 1; break; end
      end
      if (!got || e + 3 > fill_cnt) return 0;
      for (int unsigned i = s + 1; i < e; i++) x ^= lbuf[i];
      if (((hexv(lbuf[e+1]) << 4) | hexv(lbuf[e+2])) != x) return 0;
      st = s; ln = e - s + 3; pl = e - s - 1;
      return 1;
    endfunction

    function bit seek_ubx(output int unsigned st, output int unsigned ln,
                          output int unsigned pl);
      int unsigned avail, p, a, b;
      st = 0; ln = 0; pl = 0;
      for (int unsigned ix = 0; ix < fill_cnt; ix++) begin
        avail = fill_cnt - ix;
        if (avail <= 8) break;
        if (lbuf[ix] == UbxSync1 && lbuf[ix+1] == UbxSync2) begin
          p = lbuf[ix+4] | (lbuf[ix+5] << 8);
          if (avail < p + 8) break;
          a = 0; b = 0;
          for (int unsigned k = ix + 2; k < ix + 6 + p; k++) begin
            a = (a + lbuf[k]) & 8'hFF;
            b = (b + a) & 8'hFF;
          end
          if (lbuf[ix+6+p] == a && lbuf[ix+7+p] == b) begin
            st = ix; ln = p + 8; pl = p;
            return 1;
          end
        end
      end
      return 0;
    endfunction

    function bit seek_rtcm(output int unsigned st, output int unsigned ln,
                           output int unsigned pl);
      int unsigned avail, p, r;
      logic [23:0] crc;
      st = 0; ln = 0; pl = 0;
      for (int unsigned ix = 0; ix < fill_cnt; ix++) begin
        avail = fill_cnt - ix;
        if (avail <= 6) break;
        if (lbuf[ix] == RtcmPre) begin
          p = (lbuf[ix+1] << 8) | lbuf[ix+2];
          if (p != 0 && p < RtcmLenLim) begin
            if (avail < p + 6) break;
            crc = crc24_of(ix, p + 3);
            r = (lbuf[ix+p+3] << 16) | (lbuf[ix+p+4] << 8) | lbuf[ix+p+5];
            if (crc == r[23:0]) begin
              st = ix; ln = p + 6; pl = p;
              return 1;
            end
          end
        end
      end
      return 0;
    endfunction

    // Note one accepted byte and queue the descriptors it causes
    function void note_byte(byte unsigned d);
      int unsigned st, ln, pl, e, hits;
      bit ovf;
      desc_t w;
      ovf = 0; hits = 0;
      if (fill_cnt >= BufDepth) begin
        fill_cnt = 0; ovf = 1;
      end else begin
        lbuf[fill_cnt] = d; fill_cnt++;
      end
      if (fill_cnt >= BufDepth) begin fill_cnt = 0; ovf = 1; end
      if (peak_cnt < fill_cnt) peak_cnt = fill_cnt;
      while (fill_cnt != 0 && hits < MaxHits) begin
        w = '{default: '0};
        if (seek_nmea(st, ln, pl)) w.kind = KindNmea;
        else if (seek_ubx(st, ln, pl)) begin
          w.kind = KindUbx; w.cls = lbuf[st+2]; w.id = lbuf[st+3];
        end else if (seek_rtcm(st, ln, pl)) w.kind = KindRtcm;
        else break;
        e = st + ln;
        if (e <= fill_cnt) begin
          for (int unsigned i = 0; i < fill_cnt - e; i++) lbuf[i] = lbuf[i+e];
          fill_cnt -= e;
        end else fill_cnt = 0;
        w.start = st[10:0]; w.flen = ln[11:0]; w.plen = pl[11:0];
        w.fill = fill_cnt[11:0]; w.peak = peak_cnt[11:0]; w.ovf = ovf;
        pending.push_back(w);
        hits++;
      end
      if (hits == 0) begin
        w = '{default: '0};
        w.fill = fill_cnt[11:0]; w.peak = peak_cnt[11:0]; w.ovf = ovf;
        pending.push_back(w);
      end
      pending[$].last = 1;
    endfunction

    // Compare one output word with the oldest expectation
    function void check_word(logic [1:0] kind, logic [79:0] d, logic lst);
      desc_t x;
      bit bad;
      n_words++;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected word kind=%0d data=%h", kind, d);
        return;
      end
      x = pending.pop_front();
      bad = (kind !== x.kind) || (d[10:0] !== x.start) || (d[22:11] !== x.flen) ||
            (d[34:23] !== x.plen) || (d[42:35] !== x.cls) || (d[50:43] !== x.id) ||
            (d[62:51] !== x.fill) || (d[74:63] !== x.peak) || (d[75] !== x.ovf) ||
            (d[79:76] !== 4'd0) || (lst !== x.last);
      if (bad) begin
        n_err++;
        if (n_err <= 10)
          $display({"ERROR: word %0d exp kind=%0d st=%0d len=%0d pay=%0d cls=%h id=%h ",
                    "fill=%0d peak=%0d ovf=%0d last=%0d | got kind=%0d st=%0d len=%0d ",
                    "pay=%0d cls=%h id=%h fill=%0d peak=%0d ovf=%0d last=%0d"},
                   n_words, x.kind, x.start, x.flen, x.plen, x.cls, x.id, x.fill,
                   x.peak, x.ovf, x.last, kind, d[10:0], d[22:11], d[34:23],
                   d[42:35], d[50:43], d[62:51], d[74:63], d[75], lst);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  gnss_frame_demux_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  frame_scoreboard sb = new();
  int  send_idle_pct = 9;
  int  recv_idle_pct = 48;
  bit  hold_off = 0;
  bit  timed_out = 0;
  int  n_bytes = 0;
  int  n_frames[4] = '{0, 0, 0, 0};
  longint cycle_cnt = 0;
  byte unsigned msg[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd40_000_000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        n_frames[m_axis_tuser]++;
      end
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one byte, with random gaps before it; ready is looked at mid-cycle
  task automatic put_byte(input byte unsigned d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_byte(d);
    n_bytes++;
  endtask

  task automatic put_msg();
    foreach (msg[i]) put_byte(msg[i]);
    msg.delete();
  endtask

  function automatic byte unsigned hexch(int unsigned v);
    return (v < 10) ? 8'(v + "0") : 8'(v - 10 + (($urandom_range(1)) ? "A" : "a"));
  endfunction

  // NMEA sentence; bad corrupts the checksum
  task automatic build_nmea(int unsigned n, bit bad);
    byte unsigned x, c;
    x = 0;
    msg.push_back(ChDollar);
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(32, 126)); while (c == ChDollar || c == ChStar);
      msg.push_back(c);
      x ^= c;
    end
    if (bad) x ^= 8'h5A;
    msg.push_back(ChStar);
    msg.push_back(hexch(x[7:4]));
    msg.push_back(hexch(x[3:0]));
  endtask

  task automatic build_ubx(int unsigned n, bit bad);
    byte unsigned a, b, body[$];
    a = 0; b = 0;
    body.push_back(8'($urandom)); body.push_back(8'($urandom));
    body.push_back(8'(n)); body.push_back(8'(n >> 8));
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    foreach (body[i]) begin a += body[i]; b += a; end
    msg.push_back(UbxSync1); msg.push_back(UbxSync2);
    foreach (body[i]) msg.push_back(body[i]);
    msg.push_back(a); msg.push_back(bad ? b ^ 8'h01 : b);
  endtask

  // UBX frame with a bad checksum wrapping two good UBX frames: its header
  // holds back the UBX search until its last byte, which releases both
  task automatic build_ubx_pair();
    byte unsigned a, b, inner[$], body[$];
    a = 0; b = 0;
    build_ubx(2, 0); build_ubx(2, 0);
    inner = msg;
    msg.delete();
    inner.push_back(8'h00); inner.push_back(8'h00);
    body = '{8'h01, 8'h02, 8'(inner.size()), 8'h00};
    foreach (inner[i]) body.push_back(inner[i]);
    foreach (body[i]) begin a += body[i]; b += a; end
    msg.push_back(UbxSync1); msg.push_back(UbxSync2);
    foreach (body[i]) msg.push_back(body[i]);
    msg.push_back(a ^ 8'h01); msg.push_back(b);
  endtask

  task automatic build_rtcm(int unsigned n, bit bad);
    logic [24:0] c;
    byte unsigned body[$];
    c = '0;
    body.push_back(RtcmPre); body.push_back(8'(n >> 8)); body.push_back(8'(n));
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    foreach (body[i]) begin
      c[23:16] ^= body[i];
      for (int j = 0; j < 8; j++) begin
        c = {c[23:0], 1'b0};
        if (c[24]) c ^= Crc24Poly;
      end
    end
    if (bad) c[0] = ~c[0];
    foreach (body[i]) msg.push_back(body[i]);
    msg.push_back(c[23:16]); msg.push_back(c[15:8]); msg.push_back(c[7:0]);
  endtask

  // Stop offering and wait for every expected word
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme bytes, each frame kind, bad checksums, zero stop
    put_byte(8'h00); put_byte(8'hFF);
    build_nmea(3, 0); put_msg();
    build_ubx(0, 0); put_msg();
    build_rtcm(1, 0); put_msg();
    build_nmea(2, 1); put_msg();
    msg.push_back(8'h00); build_nmea(1, 0); put_msg();
    build_ubx(1, 1); build_rtcm(2, 1); put_msg();
    // several frames completed by one byte
    build_ubx_pair(); put_msg();
    wait_drain();

    // Random phases with three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 9 : 0;
      for (int f = 0; f < 7; f++) begin
        sel = $urandom_range(9);
        case (sel)
          0, 1, 2: build_nmea($urandom_range(0, 12), $urandom_range(7) == 0);
          3, 4, 5: build_ubx($urandom_range(0, 8), $urandom_range(7) == 0);
          6, 7:    build_rtcm($urandom_range(1, 8), $urandom_range(7) == 0);
          8:       repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
          default: msg.push_back(8'h00);
        endcase
        put_msg();
        // long receiver hold-off while bytes keep coming
        if (ph == 2 && f == 3) begin
          hold_off = 1;
          fork
            begin repeat (3000) @(posedge clk_i); hold_off = 0; end
          join_none
          repeat (6) begin build_nmea(1, 0); put_msg(); end
        end
      end
    end

    wait_drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d bytes; saw %0d idle, %0d NMEA, %0d UBX, %0d RTCM3 words",
             n_bytes, n_frames[0], n_frames[1], n_frames[2], n_frames[3]);
    $display("Covered bad checksums, zero stops, several frames per byte and stalls");
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.n_err);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== gnss_frame_demux_unit.f =====
rtl/gfd_pkg.sv
rtl/gfd_ram.sv
rtl/gfd_scan.sv
rtl/gnss_frame_demux_unit.sv
bench/gnss_frame_demux_unit_tb.sv
